// ===== src/lbpq_pkg.sv =====
// ---------------------------------------------------------------------------
// lbpq_pkg
// Types, sizes and helpers shared by the LED blink pattern queue block.
// ---------------------------------------------------------------------------
package lbpq_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int NUM_LEDS    = 3;

   localparam int LED_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W  = $clog2(NUM_LEDS * QUEUE_DEPTH);
   localparam int COUNT_W = 16;
   localparam int PHASE_W = 8;
   localparam int PERIOD_W = 10;
   localparam int FLAG_W  = 3;

   typedef logic [LED_W-1:0]    led_idx_type;
   typedef logic [QIDX_W-1:0]   qidx_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [PERIOD_W-1:0] period_type;

   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic [PHASE_W-1:0] on1;
      logic [PHASE_W-1:0] off1;
      logic [PHASE_W-1:0] on2;
      logic [PHASE_W-1:0] off2;
      period_type         period;
   } pattern_type;

   localparam int PATTERN_W = $bits(pattern_type);

   typedef enum logic [1:0] {
      QS_EMPTY = 2'd0,
      QS_PART  = 2'd1,
      QS_FULL  = 2'd2
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ,
      ST_SCAN,
      ST_LOAD,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      logic     div_start;
      logic     next_led;
      logic     rsp_load;
   } ctl_type;

   function automatic qidx_type qidx_next(input qidx_type idx);
      qidx_type res;
      if (int'(idx) == QUEUE_DEPTH - 1) begin
         res = '0;
      end else begin
         res = idx + qidx_type'(1);
      end
      return res;
   endfunction

   function automatic addr_type pat_addr(input led_idx_type led, input qidx_type idx);
      return addr_type'(int'(led) * QUEUE_DEPTH + int'(idx));
   endfunction

endpackage

// ===== src/lbpq_pattern_ram.sv =====
// ---------------------------------------------------------------------------
// lbpq_pattern_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
module lbpq_pattern_ram #(
   parameter int DATA_W = 58,
   parameter int DEPTH  = 12,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lbpq_mod_unit.sv =====
// ---------------------------------------------------------------------------
// lbpq_mod_unit
// Restoring remainder unit: tick count modulo pattern period, one bit a cycle.
// ---------------------------------------------------------------------------
module lbpq_mod_unit
   import lbpq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  count_type  dividend,
   input  period_type divisor,
   output logic       done,
   output period_type remainder
);

   localparam int STEP_W = $clog2(COUNT_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   count_type           dvd_ff, dvd_in;
   period_type          dvs_ff, dvs_in;
   period_type          rem_ff, rem_in;
   logic [PERIOD_W:0]   shifted;

   assign shifted = {rem_ff, dvd_ff[COUNT_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(COUNT_W);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[COUNT_W-2:0], 1'b0};
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = PERIOD_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[PERIOD_W-1:0];
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/led_blink_pattern_queue_core.sv =====
// ---------------------------------------------------------------------------
// led_blink_pattern_queue_core
// Three LEDs, each with a circular queue of blink patterns.
//
// The req_ channel takes one item: a tick (req_kind 0) or an enqueue of a
// pattern for LED req_led_id (req_kind 1). Each item gives exactly one item
// on the rsp_ channel: the accept flag of an enqueue (1 for a tick) and the
// LED levels, full flags and empty flags after the item is applied.
// Patterns live in a RAM with registered reads; per-LED indexes,
// counters and levels sit in registers.
// An enqueue passes the enqueue state and then the done state. A tick walks the
// LEDs one after another: an empty queue is skipped in the scan state, a served
// queue is read and compared and, unless it drains or its period is zero, gets
// a bit-serial remainder of the tick count by the period for the new LED level.
// One item is in work at a time; req_ready is high while the block is idle.
// A result waits in an output register; while rsp_ready is low the next item
// may still be taken and worked, then it holds in the done state until free.
// Reset (synchronous) empties all queues, clears counters and turns LEDs off;
// no clearing pass is run on the pattern RAM.
// ---------------------------------------------------------------------------
module led_blink_pattern_queue_core
   import lbpq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [1:0]       req_led_id,
   input  logic [15:0]      req_total_ticks,
   input  logic [7:0]       req_on_first,
   input  logic [7:0]       req_off_first,
   input  logic [7:0]       req_on_second,
   input  logic [7:0]       req_off_second,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_accepted,
   output logic [2:0]       rsp_led_levels,
   output logic [2:0]       rsp_full_flags,
   output logic [2:0]       rsp_empty_flags
);

   fsm_state_type    state_ff, state_in;
   led_idx_type      led_ff, led_in;
   logic             inc_ff, inc_in;
   logic             acc_ff, acc_in;

   logic             kind_ff;
   logic [1:0]       led_id_ff;
   pattern_type      req_pat_ff;

   qidx_type         head_ff   [NUM_LEDS];
   qidx_type         head_in   [NUM_LEDS];
   qidx_type         tail_ff   [NUM_LEDS];
   qidx_type         tail_in   [NUM_LEDS];
   queue_status_type status_ff [NUM_LEDS];
   queue_status_type status_in [NUM_LEDS];
   count_type        count_ff  [NUM_LEDS];
   count_type        count_in  [NUM_LEDS];
   logic             level_ff  [NUM_LEDS];
   logic             level_in  [NUM_LEDS];

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_acc_ff;
   logic [FLAG_W-1:0] rsp_lvl_ff, rsp_full_ff, rsp_empty_ff;
   logic [FLAG_W-1:0] lvl_vec, full_vec, empty_vec;

   ctl_type          ctl;
   logic [PATTERN_W-1:0] rd_data;
   pattern_type      cur_pat;
   logic             div_done;
   period_type       div_rem;

   led_idx_type      enq_led;
   logic             enq_ok;
   logic             last_led;
   logic             empty_cur;
   logic             hit;
   logic             drained;
   logic             zero_period;
   period_type       edge1, edge2;
   logic             phase_level;

   assign req_ready = (state_ff == ST_IDLE);
   assign cur_pat   = pattern_type'(rd_data);

   assign enq_led     = led_idx_type'(led_id_ff);
   assign enq_ok      = (int'(led_id_ff) < NUM_LEDS) && (status_ff[enq_led] != QS_FULL);
   assign last_led    = (int'(led_ff) == NUM_LEDS - 1);
   assign empty_cur   = (status_ff[led_ff] == QS_EMPTY);
   assign hit         = (cur_pat.total == count_ff[led_ff]);
   assign drained     = (qidx_next(head_ff[led_ff]) == tail_ff[led_ff]);
   assign zero_period = (cur_pat.period == '0);

   lbpq_pattern_ram #(
      .DATA_W (PATTERN_W),
      .DEPTH  (NUM_LEDS * QUEUE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_addr),
      .wr_data (req_pat_ff),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.rd_addr),
      .rd_data (rd_data)
   );

   lbpq_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl.div_start),
      .dividend  (count_ff[led_ff]),
      .divisor   (cur_pat.period),
      .done      (div_done),
      .remainder (div_rem)
   );

   // phase edges of the head pattern, applied to the remainder
   always_comb begin
      edge1 = period_type'({2'b00, cur_pat.on1}) + period_type'({2'b00, cur_pat.off1});
      edge2 = edge1 + period_type'({2'b00, cur_pat.on2});
      phase_level = level_ff[led_ff];
      if (div_rem < edge1) begin
         if (div_rem == '0) begin
            phase_level = (cur_pat.on1 != '0);
         end else if (div_rem == period_type'({2'b00, cur_pat.on1})) begin
            phase_level = 1'b0;
         end
      end else if (div_rem == edge1) begin
         if (cur_pat.on2 != '0) begin
            phase_level = 1'b1;
         end
      end else if (div_rem == edge2) begin
         phase_level = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_kind ? ST_ENQ : ST_SCAN;
            end
         end
         ST_ENQ: begin
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (empty_cur) begin
               state_in = last_led ? ST_DONE : ST_SCAN;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (hit && drained) begin
               state_in = last_led ? ST_DONE : ST_SCAN;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (zero_period) begin
               state_in = last_led ? ST_DONE : ST_SCAN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = last_led ? ST_DONE : ST_SCAN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control strobes
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_ENQ: begin
            ctl.wr_en   = enq_ok;
            ctl.wr_addr = pat_addr(enq_led, tail_ff[enq_led]);
         end
         ST_SCAN: begin
            ctl.rd_en    = !empty_cur;
            ctl.rd_addr  = pat_addr(led_ff, head_ff[led_ff]);
            ctl.next_led = empty_cur;
         end
         ST_LOAD: begin
            // head moves on: fetch the new head for evaluation
            ctl.rd_en    = hit && !drained;
            ctl.rd_addr  = pat_addr(led_ff, qidx_next(head_ff[led_ff]));
            ctl.next_led = hit && drained;
         end
         ST_EVAL: begin
            ctl.div_start = !zero_period;
            ctl.next_led  = zero_period;
         end
         ST_DIV: begin
            ctl.next_led = div_done;
         end
         ST_DONE: begin
            ctl.rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // per-LED queue state
   always_comb begin
      for (int i = 0; i < NUM_LEDS; i++) begin
         head_in[i]   = head_ff[i];
         tail_in[i]   = tail_ff[i];
         status_in[i] = status_ff[i];
         count_in[i]  = count_ff[i];
         level_in[i]  = level_ff[i];
      end
      led_in = led_ff;
      inc_in = inc_ff;
      acc_in = acc_ff;
      if (state_ff == ST_IDLE && req_valid) begin
         led_in = '0;
         acc_in = 1'b1;
      end
      if (ctl.next_led && !last_led) begin
         led_in = led_ff + led_idx_type'(1);
      end
      case (state_ff)
         ST_ENQ: begin
            acc_in = enq_ok;
            if (enq_ok) begin
               count_in[enq_led] = '0;
               tail_in[enq_led]  = qidx_next(tail_ff[enq_led]);
               status_in[enq_led] =
                  (head_ff[enq_led] == qidx_next(tail_ff[enq_led])) ? QS_FULL : QS_PART;
            end
         end
         ST_LOAD: begin
            inc_in = !hit;
            if (hit) begin
               count_in[led_ff] = '0;
               head_in[led_ff]  = qidx_next(head_ff[led_ff]);
               if (drained) begin
                  status_in[led_ff] = QS_EMPTY;
                  level_in[led_ff]  = 1'b0;
               end else begin
                  status_in[led_ff] = QS_PART;
               end
            end
         end
         ST_EVAL: begin
            if (zero_period) begin
               level_in[led_ff] = 1'b0;
               if (inc_ff) begin
                  count_in[led_ff] = count_ff[led_ff] + count_type'(1);
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               level_in[led_ff] = phase_level;
               if (inc_ff) begin
                  count_in[led_ff] = count_ff[led_ff] + count_type'(1);
               end
            end
         end
         default: begin
            led_in = led_in;
         end
      endcase
   end

   genvar g;
   generate
      for (g = 0; g < FLAG_W; g++) begin : g_flags
         if (g < NUM_LEDS) begin : g_on
            assign lvl_vec[g]   = level_ff[g];
            assign full_vec[g]  = (status_ff[g] == QS_FULL);
            assign empty_vec[g] = (status_ff[g] == QS_EMPTY);
         end else begin : g_off
            assign lvl_vec[g]   = 1'b0;
            assign full_vec[g]  = 1'b0;
            assign empty_vec[g] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         led_ff       <= '0;
         inc_ff       <= 1'b0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEDS; i++) begin
            head_ff[i]   <= '0;
            tail_ff[i]   <= '0;
            status_ff[i] <= QS_EMPTY;
            count_ff[i]  <= '0;
            level_ff[i]  <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         led_ff       <= led_in;
         inc_ff       <= inc_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_LEDS; i++) begin
            head_ff[i]   <= head_in[i];
            tail_ff[i]   <= tail_in[i];
            status_ff[i] <= status_in[i];
            count_ff[i]  <= count_in[i];
            level_ff[i]  <= level_in[i];
         end
      end
   end

   // item capture and result registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         kind_ff           <= req_kind;
         led_id_ff         <= req_led_id;
         req_pat_ff.total  <= req_total_ticks;
         req_pat_ff.on1    <= req_on_first;
         req_pat_ff.off1   <= req_off_first;
         req_pat_ff.on2    <= req_on_second;
         req_pat_ff.off2   <= req_off_second;
         req_pat_ff.period <= period_type'({2'b00, req_on_first})
                            + period_type'({2'b00, req_off_first})
                            + period_type'({2'b00, req_on_second})
                            + period_type'({2'b00, req_off_second});
      end
      if (ctl.rsp_load) begin
         rsp_acc_ff   <= kind_ff ? acc_ff : 1'b1;
         rsp_lvl_ff   <= lvl_vec;
         rsp_full_ff  <= full_vec;
         rsp_empty_ff <= empty_vec;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_led_levels  = rsp_lvl_ff;
   assign rsp_full_flags  = rsp_full_ff;
   assign rsp_empty_flags = rsp_empty_ff;

   // a full or empty queue has its head and tail at the same place
   generate
      for (g = 0; g < NUM_LEDS; g++) begin : g_chk
         a_ptr_match : assert property (@(posedge clock) disable iff (reset)
            (status_ff[g] == QS_FULL || status_ff[g] == QS_EMPTY) |-> head_ff[g] == tail_ff[g])
            else $error("queue status disagrees with head and tail");
      end
   endgenerate

   a_no_rw_overlap : assert property (@(posedge clock) disable iff (reset)
      !(ctl.wr_en && ctl.rd_en))
      else $error("pattern ram written and read in the same cycle");

   a_div_in_state : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("remainder finished outside the divide state");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done state");

endmodule

// ===== tb/blink_test_pkg.sv =====
// ---------------------------------------------------------------------------
// blink_test_pkg
// Item kinds and LED codes shared by the blink pattern queue testbench.
// ---------------------------------------------------------------------------
package blink_test_pkg;

   typedef enum logic {
      KIND_TICK    = 1'b0,
      KIND_ENQUEUE = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      LED_GREEN = 2'd0,
      LED_RED   = 2'd1,
      LED_WHITE = 2'd2,
      LED_NONE  = 2'd3
   } led_code_type;

   // one response item as seen on the rsp_ channel
   typedef struct packed {
      logic       accepted;
      logic [2:0] levels;
      logic [2:0] full;
      logic [2:0] empty;
   } blink_status_type;

endpackage

// ===== tb/blink_status_checker.sv =====
// ---------------------------------------------------------------------------
// blink_status_checker
// Watches both channels of the blink pattern queue, keeps its own copy of
// the per-LED queues, counters and levels, and compares every response item
// field by field with the status predicted for the oldest open request.
// ---------------------------------------------------------------------------
module blink_status_checker
   import lbpq_pkg::*;
   import blink_test_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [1:0]  req_led_id,
   input  logic [15:0] req_total_ticks,
   input  logic [7:0]  req_on_first,
   input  logic [7:0]  req_off_first,
   input  logic [7:0]  req_on_second,
   input  logic [7:0]  req_off_second,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic [2:0]  rsp_led_levels,
   input  logic [2:0]  rsp_full_flags,
   input  logic [2:0]  rsp_empty_flags,
   output int          error_count,
   output int          pending_count,
   output int          reject_count,
   output int          retire_count
);
   timeunit 1ns;
   timeprecision 1ps;

   pattern_type      pat_mem [NUM_LEDS][QUEUE_DEPTH];
   qidx_type         head_q  [NUM_LEDS];
   qidx_type         tail_q  [NUM_LEDS];
   queue_status_type qstat   [NUM_LEDS];
   count_type        ticks   [NUM_LEDS];
   logic             lit     [NUM_LEDS];

   blink_status_type expected_status_q [$];

   function automatic qidx_type step_index(input qidx_type idx);
      return qidx_type'((int'(idx) + 1) % QUEUE_DEPTH);
   endfunction

   // level changes only at phase edges, held in between
   function automatic void update_led_level(input int led);
      pattern_type p;
      int unsigned t;
      int unsigned edge1;
      p = pat_mem[led][head_q[led]];
      if (p.period == '0) begin
         lit[led] = 1'b0;
         return;
      end
      t = ticks[led] % p.period;
      edge1 = p.on1 + p.off1;
      if (t < edge1) begin
         if (t == 0) begin
            lit[led] = (p.on1 != '0);
         end else if (t == p.on1) begin
            lit[led] = 1'b0;
         end
      end else if (t == edge1) begin
         if (p.on2 != '0) begin
            lit[led] = 1'b1;
         end
      end else if (t == edge1 + p.on2) begin
         lit[led] = 1'b0;
      end
   endfunction

   function automatic logic store_pattern(input int led);
      pattern_type p;
      if (led >= NUM_LEDS || qstat[led] == QS_FULL) begin
         reject_count++;
         return 1'b0;
      end
      p.total  = req_total_ticks;
      p.on1    = req_on_first;
      p.off1   = req_off_first;
      p.on2    = req_on_second;
      p.off2   = req_off_second;
      p.period = period_type'(req_on_first) + req_off_first + req_on_second + req_off_second;
      ticks[led] = '0;
      pat_mem[led][tail_q[led]] = p;
      tail_q[led] = step_index(tail_q[led]);
      qstat[led] = (head_q[led] == tail_q[led]) ? QS_FULL : QS_PART;
      return 1'b1;
   endfunction

   function automatic void advance_tick();
      for (int led = 0; led < NUM_LEDS; led++) begin
         if (qstat[led] != QS_EMPTY) begin
            if (pat_mem[led][head_q[led]].total == ticks[led]) begin
               ticks[led] = '0;
               head_q[led] = step_index(head_q[led]);
               retire_count++;
               if (head_q[led] == tail_q[led]) begin
                  qstat[led] = QS_EMPTY;
                  lit[led] = 1'b0;
               end else begin
                  qstat[led] = QS_PART;
                  update_led_level(led);
               end
            end else begin
               update_led_level(led);
               ticks[led] = ticks[led] + count_type'(1);
            end
         end
      end
   endfunction

   function automatic blink_status_type predict_status();
      blink_status_type s;
      s = '0;
      if (req_kind == KIND_ENQUEUE) begin
         s.accepted = store_pattern(int'(req_led_id));
      end else begin
         advance_tick();
         s.accepted = 1'b1;
      end
      for (int led = 0; led < NUM_LEDS && led < 3; led++) begin
         s.levels[led] = lit[led];
         s.full[led]   = (qstat[led] == QS_FULL);
         s.empty[led]  = (qstat[led] == QS_EMPTY);
      end
      return s;
   endfunction

   always @(posedge clock) begin
      blink_status_type got;
      blink_status_type want;
      if (reset) begin
         for (int led = 0; led < NUM_LEDS; led++) begin
            head_q[led] = '0;
            tail_q[led] = '0;
            qstat[led]  = QS_EMPTY;
            ticks[led]  = '0;
            lit[led]    = 1'b0;
         end
         expected_status_q.delete();
         error_count   = 0;
         pending_count = 0;
         reject_count  = 0;
         retire_count  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.accepted = rsp_accepted;
            got.levels   = rsp_led_levels;
            got.full     = rsp_full_flags;
            got.empty    = rsp_empty_flags;
            if (expected_status_q.size() == 0) begin
               error_count++;
               $error("response item with no request outstanding");
            end else begin
               want = expected_status_q.pop_front();
               if (got.accepted !== want.accepted) begin
                  error_count++;
                  $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
               end
               if (got.levels !== want.levels) begin
                  error_count++;
                  $error("led_levels: expected %b, got %b", want.levels, got.levels);
               end
               if (got.full !== want.full) begin
                  error_count++;
                  $error("full_flags: expected %b, got %b", want.full, got.full);
               end
               if (got.empty !== want.empty) begin
                  error_count++;
                  $error("empty_flags: expected %b, got %b", want.empty, got.empty);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_status_q.push_back(predict_status());
         end
         pending_count = expected_status_q.size();
      end
   end

endmodule

// ===== tb/led_blink_pattern_queue_core_test.sv =====
// ---------------------------------------------------------------------------
// led_blink_pattern_queue_core_test
// Drives ticks and pattern enqueues into the LED blink pattern queue with
// random gaps on both channels; the checker beside the block predicts and
// compares every response item.
// ---------------------------------------------------------------------------
module led_blink_pattern_queue_core_test
   import blink_test_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 450;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [1:0]  req_led_id;
   logic [15:0] req_total_ticks;
   logic [7:0]  req_on_first;
   logic [7:0]  req_off_first;
   logic [7:0]  req_on_second;
   logic [7:0]  req_off_second;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic [2:0]  rsp_led_levels;
   logic [2:0]  rsp_full_flags;
   logic [2:0]  rsp_empty_flags;

   int error_count;
   int pending_count;
   int reject_count;
   int retire_count;
   int tick_items;
   int enqueue_items;
   int req_calm;
   int rsp_calm;

   led_blink_pattern_queue_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_led_id      (req_led_id),
      .req_total_ticks (req_total_ticks),
      .req_on_first    (req_on_first),
      .req_off_first   (req_off_first),
      .req_on_second   (req_on_second),
      .req_off_second  (req_off_second),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accepted    (rsp_accepted),
      .rsp_led_levels  (rsp_led_levels),
      .rsp_full_flags  (rsp_full_flags),
      .rsp_empty_flags (rsp_empty_flags)
   );

   blink_status_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_led_id      (req_led_id),
      .req_total_ticks (req_total_ticks),
      .req_on_first    (req_on_first),
      .req_off_first   (req_off_first),
      .req_on_second   (req_on_second),
      .req_off_second  (req_off_second),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accepted    (rsp_accepted),
      .rsp_led_levels  (rsp_led_levels),
      .rsp_full_flags  (rsp_full_flags),
      .rsp_empty_flags (rsp_empty_flags),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .reject_count    (reject_count),
      .retire_count    (retire_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly random waits, now and then a run of back-to-back items
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // called at a rising edge, returns at the edge where the item is taken
   task automatic send_item(input item_kind_type kind, input led_code_type led,
                            input logic [15:0] total, input logic [7:0] on1,
                            input logic [7:0] off1, input logic [7:0] on2,
                            input logic [7:0] off2);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_led_id      <= led;
      req_total_ticks <= total;
      req_on_first    <= on1;
      req_off_first   <= off1;
      req_on_second   <= on2;
      req_off_second  <= off2;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      if (kind == KIND_TICK) begin
         tick_items++;
      end else begin
         enqueue_items++;
      end
   endtask

   // hold the sender off until every open request has its response
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         @(posedge clock);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      led_code_type led;
      logic [15:0]  total;
      logic [7:0]   on1;
      logic [7:0]   off1;
      logic [7:0]   on2;
      logic [7:0]   off2;
      tick_items      = 0;
      enqueue_items   = 0;
      req_calm        = 0;
      rsp_calm        = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= KIND_TICK;
      req_led_id      <= LED_GREEN;
      req_total_ticks <= '0;
      req_on_first    <= '0;
      req_off_first   <= '0;
      req_on_second   <= '0;
      req_off_second  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // tick with every queue empty, then a request for a missing LED
      send_item(KIND_TICK, LED_GREEN, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(KIND_ENQUEUE, LED_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // no second lit phase on green, zero period on red, dark first phase on white
      send_item(KIND_ENQUEUE, LED_GREEN, 16'd3, 8'd2, 8'd1, 8'd0, 8'd1);
      send_item(KIND_ENQUEUE, LED_RED, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(KIND_ENQUEUE, LED_WHITE, 16'd9, 8'd0, 8'd2, 8'd3, 8'd1);
      repeat (4) send_item(KIND_TICK, LED_NONE, 16'hA5A5, 8'h5A, 8'hC3, 8'h3C, 8'h0F);
      // fill red, then one more which bounces
      send_item(KIND_ENQUEUE, LED_RED, 16'd1, 8'd1, 8'd1, 8'd1, 8'd1);
      send_item(KIND_ENQUEUE, LED_RED, 16'd2, 8'd255, 8'd0, 8'd0, 8'd0);
      send_item(KIND_ENQUEUE, LED_RED, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(KIND_ENQUEUE, LED_RED, 16'd4, 8'd1, 8'd0, 8'd1, 8'd0);
      send_item(KIND_ENQUEUE, LED_RED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      wait_all_results();
      repeat (8) send_item(KIND_TICK, LED_WHITE, 16'h5A5A, 8'hA5, 8'h3C, 8'hC3, 8'hF0);
      send_item(KIND_ENQUEUE, LED_WHITE, 16'd2, 8'd0, 8'd0, 8'd255, 8'd255);
      send_item(KIND_TICK, LED_GREEN, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 49) == 0) begin
            wait_all_results();
         end
         total = 16'($urandom);
         on1   = 8'($urandom);
         off1  = 8'($urandom);
         on2   = 8'($urandom);
         off2  = 8'($urandom);
         if ($urandom_range(0, 9) < 7) begin
            send_item(KIND_TICK, led_code_type'($urandom_range(0, 3)), total,
                      on1, off1, on2, off2);
         end else begin
            led = ($urandom_range(0, 15) == 0) ? LED_NONE
                                                : led_code_type'($urandom_range(0, 2));
            // stored patterns stay short so queues drain and refill
            if (led != LED_NONE) begin
               total = 16'($urandom_range(0, 10));
               if ($urandom_range(0, 7) == 0) begin
                  {on1, off1, on2, off2} = '0;
               end else if ($urandom_range(0, 7) != 0) begin
                  on1  = 8'($urandom_range(0, 4));
                  off1 = 8'($urandom_range(0, 4));
                  on2  = 8'($urandom_range(0, 4));
                  off2 = 8'($urandom_range(0, 4));
               end
            end
            send_item(KIND_ENQUEUE, led, total, on1, off1, on2, off2);
         end
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("covered %0d ticks and %0d enqueues, %0d of them turned away",
               tick_items, enqueue_items, reject_count);
      $display("%0d patterns ran out and left their queues", retire_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
